/* rtl/tplt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tplt_pkg;

   // default sizes for the top-level parameters
   localparam int POS_BITS_DEF   = 24;
   localparam int COUNT_BITS_DEF = 8;

   // configuration register widths
   localparam int THR_BITS  = 8;
   localparam int TOL_BITS  = 52;
   localparam int COS_BITS  = 31;
   localparam int QUAT_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 52;

   // configuration reset values
   localparam logic [THR_BITS-1:0] STABLE_THRESHOLD_RST = 8'd15;
   localparam logic [THR_BITS-1:0] LOST_LIMIT_RST       = 8'd5;
   localparam logic [TOL_BITS-1:0] POS_TOL_SQ_RST       = 52'd107374;
   localparam logic [COS_BITS-1:0] ORIENT_COS_HALF_RST  = 31'd1073578282;

   // any axis difference at or beyond two to this power is never stable
   localparam int DIFF_LIMIT_LOG2 = 26;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STABLE_THRESHOLD = 3'd0,
      CSR_LOST_LIMIT       = 3'd1,
      CSR_POS_TOL_SQ       = 3'd2,
      CSR_ORIENT_COS_HALF  = 3'd3,
      CSR_FORCE_LOCK       = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_LOST     = 4'b0001,
      MODE_TRACKING = 4'b0010,
      MODE_LOCKED   = 4'b0100,
      MODE_PLANNING = 4'b1000
   } mode_type;

   // mode codes as seen on the result channel
   localparam logic [1:0] MODE_CODE_LOST     = 2'd0;
   localparam logic [1:0] MODE_CODE_TRACKING = 2'd1;
   localparam logic [1:0] MODE_CODE_LOCKED   = 2'd2;
   localparam logic [1:0] MODE_CODE_PLANNING = 2'd3;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_TRACKING: c = MODE_CODE_TRACKING;
         MODE_LOCKED:   c = MODE_CODE_LOCKED;
         MODE_PLANNING: c = MODE_CODE_PLANNING;
         default:       c = MODE_CODE_LOST;
      endcase
      return c;
   endfunction

   // packed stream widths, rounded up to whole bytes
   function automatic int req_data_bits(input int pos_bits);
      return ((2 + 3 * pos_bits + 4 * QUAT_BITS + 7) / 8) * 8;
   endfunction

   function automatic int rsp_data_bits(input int pos_bits);
      return ((4 + 3 * pos_bits + 4 * QUAT_BITS + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

/* rtl/target_pose_lock_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Target pose lock tracker.
// req_ channel: one transaction per event. tuser carries op (0 frame result,
// 1 lock request); tdata carries detected, lock_on, the position and the
// quaternion. rsp_ channel: exactly one result transaction per request, with
// the mode after the event, the published pose and the lock outcome.
// csr_ channel: register writes (index, data), always ready; write only while
// the block holds no pending transaction.
// Flow: a request lands in an input register, one pass of logic then
// updates mode, counters and reference and loads the result register,
// which drives rsp_tvalid. Throughput is one transaction per cycle while
// the result is not stalled; the loop that bounds it is the mode/reference
// update, which closes in one pass of logic including the stability test.
// Stall: while rsp_tready is low the result holds, and the input register
// still takes one more request; req_tready then drops until the result moves.
// Reset (synchronous, active high): mode lost, counters and reference zero,
// registers at their defaults, both channels empty.
module target_pose_lock_tracker
   import tplt_pkg::*;
#(
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: op
   input  wire logic                               req_tuser,
   // request: detected, lock_on, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
   input  wire logic [req_data_bits(POS_BITS)-1:0] req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // result: mode, pose_valid, out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz,
   // lock_success
   output logic [rsp_data_bits(POS_BITS)-1:0]      rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]          csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]           csr_data
);

   localparam int RSP_W  = rsp_data_bits(POS_BITS);
   localparam int POS_LO = 2;
   localparam int Q_LO   = POS_LO + 3 * POS_BITS;
   localparam int CMP_W  = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [THR_BITS-1:0] stable_thr_ff, lost_limit_ff;
   logic [TOL_BITS-1:0] pos_tol_ff;
   logic [COS_BITS-1:0] cos_half_ff;
   logic                force_lock_ff;

   // input register
   logic                        in_vld_ff, in_vld_in;
   logic                        in_op_ff, in_det_ff, in_lock_ff;
   logic signed [POS_BITS-1:0]  in_pos_ff  [3];
   logic signed [QUAT_BITS-1:0] in_quat_ff [4];

   // tracker state
   mode_type                    mode_ff, mode_in;
   logic [COUNT_BITS-1:0]       stable_cnt_ff, stable_cnt_in, stable_sat;
   logic [COUNT_BITS-1:0]       missed_cnt_ff, missed_cnt_in, missed_sat;
   logic signed [POS_BITS-1:0]  ref_pos_ff  [3];
   logic signed [POS_BITS-1:0]  ref_pos_in  [3];
   logic signed [QUAT_BITS-1:0] ref_quat_ff [4];
   logic signed [QUAT_BITS-1:0] ref_quat_in [4];

   // result register
   logic             out_vld_ff, out_vld_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;

   logic req_take, process, stable, take_ref, pose_valid, lock_success;
   logic signed [POS_BITS-1:0]  pub_pos  [3];
   logic signed [QUAT_BITS-1:0] pub_quat [4];

   assign req_take   = req_tvalid && req_tready;
   assign process    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || process;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_thr_ff <= STABLE_THRESHOLD_RST;
         lost_limit_ff <= LOST_LIMIT_RST;
         pos_tol_ff    <= POS_TOL_SQ_RST;
         cos_half_ff   <= ORIENT_COS_HALF_RST;
         force_lock_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_THRESHOLD: stable_thr_ff <= csr_data[THR_BITS-1:0];
            CSR_LOST_LIMIT:       lost_limit_ff <= csr_data[THR_BITS-1:0];
            CSR_POS_TOL_SQ:       pos_tol_ff    <= csr_data[TOL_BITS-1:0];
            CSR_ORIENT_COS_HALF:  cos_half_ff   <= csr_data[COS_BITS-1:0];
            CSR_FORCE_LOCK:       force_lock_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register: valid is control, payload loads on accept only
   assign in_vld_in = req_take ? 1'b1 : (process ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_det_ff  <= req_tdata[0];
         in_lock_ff <= req_tdata[1];
         for (int k = 0; k < 3; k++) begin
            in_pos_ff[k] <= req_tdata[POS_LO + k * POS_BITS +: POS_BITS];
         end
         for (int k = 0; k < 4; k++) begin
            in_quat_ff[k] <= req_tdata[Q_LO + k * QUAT_BITS +: QUAT_BITS];
         end
      end
   end

   tplt_stab #(
      .POS_BITS (POS_BITS)
   ) u_stab (
      .pos        (in_pos_ff),
      .ref_pos    (ref_pos_ff),
      .quat       (in_quat_ff),
      .ref_quat   (ref_quat_ff),
      .pos_tol_sq (pos_tol_ff),
      .cos_half   (cos_half_ff),
      .stable     (stable)
   );

   assign stable_sat = (stable_cnt_ff == COUNT_MAX) ? stable_cnt_ff : stable_cnt_ff + 1'b1;
   assign missed_sat = (missed_cnt_ff == COUNT_MAX) ? missed_cnt_ff : missed_cnt_ff + 1'b1;

   // next state for the transaction in the input register
   always_comb begin
      mode_in       = mode_ff;
      stable_cnt_in = stable_cnt_ff;
      missed_cnt_in = missed_cnt_ff;
      take_ref      = 1'b0;
      pose_valid    = 1'b0;
      lock_success  = 1'b0;

      if (in_op_ff) begin
         // lock service: lock_on takes locked to planning; lock off drops to lost
         if (in_lock_ff) begin
            if (mode_ff == MODE_LOCKED) begin
               mode_in      = MODE_PLANNING;
               lock_success = 1'b1;
            end
         end else begin
            mode_in      = MODE_LOST;
            lock_success = 1'b1;
         end
      end else if (in_det_ff) begin
         missed_cnt_in = '0;
         pose_valid    = 1'b1;
         case (mode_ff)
            MODE_LOST: begin
               mode_in       = MODE_TRACKING;
               stable_cnt_in = '0;
               take_ref      = 1'b1;
            end
            MODE_TRACKING: begin
               if (stable) begin
                  stable_cnt_in = stable_sat;
                  if (CMP_W'(stable_sat) >= CMP_W'(stable_thr_ff) || force_lock_ff) begin
                     mode_in  = MODE_LOCKED;
                     take_ref = 1'b1;
                  end
               end else begin
                  stable_cnt_in = '0;
                  take_ref      = 1'b1;
               end
            end
            default: ;
         endcase
      end else begin
         // missed frame counts only while tracking or locked
         if (mode_ff == MODE_TRACKING || mode_ff == MODE_LOCKED) begin
            missed_cnt_in = missed_sat;
            if (CMP_W'(missed_sat) > CMP_W'(lost_limit_ff)) begin
               mode_in       = MODE_LOST;
               stable_cnt_in = '0;
            end
         end
      end

      for (int k = 0; k < 3; k++) begin
         ref_pos_in[k] = take_ref ? in_pos_ff[k] : ref_pos_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         ref_quat_in[k] = take_ref ? in_quat_ff[k] : ref_quat_ff[k];
      end
   end

   // published pose: frozen reference once locked or planning, zero when none
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!pose_valid) begin
            pub_pos[k] = '0;
         end else if (mode_in == MODE_LOCKED || mode_in == MODE_PLANNING) begin
            pub_pos[k] = ref_pos_in[k];
         end else begin
            pub_pos[k] = in_pos_ff[k];
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (!pose_valid) begin
            pub_quat[k] = '0;
         end else if (mode_in == MODE_LOCKED || mode_in == MODE_PLANNING) begin
            pub_quat[k] = ref_quat_in[k];
         end else begin
            pub_quat[k] = in_quat_ff[k];
         end
      end
      out_data_in = RSP_W'({lock_success,
                            pub_quat[3], pub_quat[2], pub_quat[1], pub_quat[0],
                            pub_pos[2], pub_pos[1], pub_pos[0],
                            pose_valid, mode_code(mode_in)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LOST;
         stable_cnt_ff <= '0;
         missed_cnt_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            ref_pos_ff[k] <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            ref_quat_ff[k] <= '0;
         end
      end else if (process) begin
         mode_ff       <= mode_in;
         stable_cnt_ff <= stable_cnt_in;
         missed_cnt_ff <= missed_cnt_in;
         ref_pos_ff    <= ref_pos_in;
         ref_quat_ff   <= ref_quat_in;
      end
   end

   // result register
   assign out_vld_in = process ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tplt_stab.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stability test of one pose against the reference: squared distance and
// absolute quaternion dot product, all in parallel.
module tplt_stab
   import tplt_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  wire logic signed [POS_BITS-1:0]  pos      [3],
   input  wire logic signed [POS_BITS-1:0]  ref_pos  [3],
   input  wire logic signed [QUAT_BITS-1:0] quat     [4],
   input  wire logic signed [QUAT_BITS-1:0] ref_quat [4],
   input  wire logic [TOL_BITS-1:0]         pos_tol_sq,
   input  wire logic [COS_BITS-1:0]         cos_half,
   output logic                             stable
);

   localparam int DW    = POS_BITS + 1;
   localparam int MAG_W = (DW < DIFF_LIMIT_LOG2) ? DW : DIFF_LIMIT_LOG2;
   localparam int LIM_W = (DW > DIFF_LIMIT_LOG2 + 1) ? DW : DIFF_LIMIT_LOG2 + 1;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int CMP_W = (SUM_W > TOL_BITS) ? SUM_W : TOL_BITS;
   localparam int PROD_W = 2 * QUAT_BITS;
   localparam int DOT_W  = PROD_W + 2;

   logic signed [DW-1:0]     diff   [3];
   logic        [DW-1:0]     mag    [3];
   logic        [2:0]        too_far;
   logic        [SQ_W-1:0]   sq     [3];
   logic        [SUM_W-1:0]  dist_sq;
   logic signed [PROD_W-1:0] prod   [4];
   logic signed [DOT_W-1:0]  dot;
   logic        [DOT_W-1:0]  dot_abs;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]    = DW'(pos[k]) - DW'(ref_pos[k]);
         mag[k]     = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
         too_far[k] = LIM_W'(mag[k]) >= (LIM_W'(1) << DIFF_LIMIT_LOG2);
         sq[k]      = SQ_W'(mag[k][MAG_W-1:0]) * SQ_W'(mag[k][MAG_W-1:0]);
      end
      dist_sq = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

      for (int k = 0; k < 4; k++) begin
         prod[k] = PROD_W'(quat[k]) * PROD_W'(ref_quat[k]);
      end
      dot     = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]) + DOT_W'(prod[3]);
      dot_abs = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);

      stable = (too_far == 3'b000)
             && (CMP_W'(dist_sq) <= CMP_W'(pos_tol_sq))
             && (dot_abs > DOT_W'(cos_half));
   end

endmodule

`default_nettype wire

/* rtl/tplt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tplt_checker
   import tplt_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic [rsp_data_bits(POS_BITS)-1:0] rsp_tdata,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready
);

   localparam int POSE_W  = 3 * POS_BITS + 4 * QUAT_BITS;
   localparam int SUCC_AT = 3 + POSE_W;

   logic [1:0]        mode;
   logic              pose_valid;
   logic              lock_success;
   logic [POSE_W-1:0] pose;

   assign mode         = rsp_tdata[1:0];
   assign pose_valid   = rsp_tdata[2];
   assign pose         = rsp_tdata[3 +: POSE_W];
   assign lock_success = rsp_tdata[SUCC_AT];

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // results without a pose carry a zero pose
   a_no_pose_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !pose_valid) |-> (pose == '0))
      else $error("pose fields set without pose_valid");

   // a published pose never leaves the mode lost
   a_pose_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pose_valid) |-> (mode != MODE_CODE_LOST))
      else $error("pose published in lost mode");

   // a granted lock request ends in planning or lost and has no pose
   a_lock_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && lock_success) |->
         (!pose_valid && (mode == MODE_CODE_PLANNING || mode == MODE_CODE_LOST)))
      else $error("inconsistent lock result");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");

endmodule

bind target_pose_lock_tracker tplt_checker #(
   .POS_BITS (POS_BITS)
) u_tplt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
